>>> design/dpsw_pkg.sv
`default_nettype none

package dpsw_pkg;

    // field and register widths
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 24;
    localparam int WORD_W     = 32;
    localparam int PKT_CNT_W  = 20;
    localparam int LIMIT_W    = 20;
    localparam int PAYLOAD_W  = 24;
    localparam int DUR_W      = 28;
    localparam int CAUSE_W    = 3;
    localparam int CFG_DATA_W = 24;

    // archive packet layout
    localparam logic [COUNT_W-1:0] ARCHIVE_LAST      = 24'd184;
    localparam logic [COUNT_W-1:0] ARCHIVE_STAMP_POS = 24'd37;
    localparam logic [COUNT_W-1:0] ARCHIVE_TIME_END  = 24'd41;
    localparam logic [COUNT_W-1:0] ARCHIVE_FLAG_POS  = 24'd53;
    localparam logic [COUNT_W-1:0] ARCHIVE_GATE_END  = 24'd57;
    localparam logic [COUNT_W-1:0] GATE_EXTRA        = 24'd6;
    localparam logic [COUNT_W-1:0] PREFIX_SHORT      = 24'd4;
    localparam logic [COUNT_W-1:0] PREFIX_LONG       = 24'd8;

    // packet type codes
    localparam logic [BYTE_W-1:0] TYPE_END     = 8'd0;
    localparam logic [BYTE_W-1:0] TYPE_ARCHIVE = 8'd1;
    localparam logic [BYTE_W-1:0] TYPE_SHORT   = 8'd2;
    localparam logic [BYTE_W-1:0] TYPE_LONG    = 8'd3;

    // one day in milliseconds
    localparam logic [WORD_W:0] DAY_MS = 33'd86400000;

    // register reset values
    localparam logic [LIMIT_W-1:0]   PACKET_LIMIT_RESET = 20'd400000;
    localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_RESET  = 24'h020000;

    // configuration register indexes
    localparam logic CFG_PACKET_LIMIT = 1'b0;
    localparam logic CFG_MAX_PAYLOAD  = 1'b1;

    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_ARCHIVE = 3'd1,
        PH_GATE    = 3'd2,
        PH_PREFIX  = 3'd3,
        PH_LEN     = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_END_MARK  = 3'd0,
        CAUSE_BAD_TYPE  = 3'd1,
        CAUSE_TOO_LONG  = 3'd2,
        CAUSE_INPUT_END = 3'd3,
        CAUSE_LIMIT     = 3'd4
    } cause_t;

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
        logic              stream_end;
    } item_t;

    typedef struct packed {
        logic             valid;
        logic [DUR_W-1:0] duration;
        cause_t           cause;
    } result_t;

endpackage

`default_nettype wire

>>> design/demo_packet_stream_walker_core.sv
// result path: the item that stops the walk is first held in the input register, then
//   stepped and its result loaded into the result register once that register has space
// throughput: one item per cycle; each item is stepped combinationally between the
//   input register and the result register; a result left waiting in the result register
//   holds the walker, and input stalls once the input register is full
// reset: asynchronous active low; the walk restarts awaiting a type byte with all
//   counters and times cleared, packet_limit 400000 and max_payload 0x20000
`default_nettype none

module demo_packet_stream_walker_core
    import dpsw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  stream_valid,
    output logic                       stream_ready,
    input  wire logic [BYTE_W-1:0]     stream_byte,
    input  wire logic                  stream_end,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output logic signed [DUR_W-1:0]    walk_span,
    output logic [CAUSE_W-1:0]         stop_cause
);

    logic [LIMIT_W-1:0]   packet_limit_reg;
    logic [PAYLOAD_W-1:0] max_payload_reg;
    item_t                item_in;
    item_t                held_item;
    logic                 held_valid;
    logic                 out_space;
    logic                 advance;
    result_t              step_result;
    logic [DUR_W-1:0]     out_duration;
    cause_t               out_cause;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_limit_reg <= PACKET_LIMIT_RESET;
            max_payload_reg  <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MAX_PAYLOAD)
            begin
                max_payload_reg <= cfg_data[PAYLOAD_W-1:0];
            end
            else
            begin
                packet_limit_reg <= cfg_data[LIMIT_W-1:0];
            end
        end
    end

    assign item_in.stream_byte = stream_byte;
    assign item_in.stream_end  = stream_end;

    // the held item steps when the result register can take its result
    assign advance = held_valid && out_space;

    dpsw_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_valid (stream_valid),
        .stream_ready (stream_ready),
        .item_in      (item_in),
        .take         (advance),
        .held_valid   (held_valid),
        .held_item    (held_item)
    );

    dpsw_walker u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (held_item),
        .packet_limit (packet_limit_reg),
        .max_payload  (max_payload_reg),
        .result       (step_result)
    );

    dpsw_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .result       (step_result),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .space        (out_space),
        .duration     (out_duration),
        .cause        (out_cause)
    );

    assign walk_span  = $signed(out_duration);
    assign stop_cause = out_cause;

endmodule

`default_nettype wire

>>> design/dpsw_in_stage.sv
`default_nettype none

module dpsw_in_stage
    import dpsw_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  stream_valid,
    output logic       stream_ready,
    input  wire item_t item_in,
    input  wire logic  take,
    output logic       held_valid,
    output item_t      held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // space when empty or when the held item moves on this cycle
    assign stream_ready = !valid_reg || take;
    assign valid_next   = stream_valid || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (stream_valid && stream_ready)
        begin
            item_reg <= item_in;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

>>> design/dpsw_walker.sv
`default_nettype none

module dpsw_walker
    import dpsw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire item_t                item,
    input  wire logic [LIMIT_W-1:0]   packet_limit,
    input  wire logic [PAYLOAD_W-1:0] max_payload,
    output result_t                   result
);

    phase_t               phase_reg, phase_next;
    logic [COUNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [WORD_W-1:0]    length_word_reg, length_word_next;
    logic [WORD_W-1:0]    time_capture_reg, time_capture_next;
    logic                 gate_nonzero_reg, gate_nonzero_next;
    logic [WORD_W-1:0]    first_time_reg, first_time_next;
    logic [WORD_W-1:0]    last_time_reg, last_time_next;
    logic                 have_first_reg, have_first_next;
    logic [PKT_CNT_W-1:0] packet_count_reg, packet_count_next;
    logic                 walk_stopped_reg, walk_stopped_next;

    logic [COUNT_W-1:0]   count_dec;
    logic [PKT_CNT_W-1:0] count_inc;
    logic [WORD_W-1:0]    byte_wide;
    logic [WORD_W-1:0]    len_merged;
    logic [1:0]           time_lane;
    logic                 limit_hit;
    logic                 emit_req;
    logic                 done_req;
    logic                 clear_req;
    cause_t               cause;
    logic [WORD_W:0]      diff;
    logic                 diff_ok;

    // helpers for the step logic; count_dec is shared by several phases
    assign count_dec  = (byte_count_reg != '0) ? (byte_count_reg - 24'd1) : '0;
    assign count_inc  = (packet_count_reg != '1) ? (packet_count_reg + 20'd1)
                                                 : packet_count_reg;
    assign byte_wide  = {24'd0, item.stream_byte};
    assign len_merged = length_word_reg | (byte_wide << {byte_count_reg[1:0], 3'b000});
    assign time_lane  = byte_count_reg[1:0] - 2'd1;
    assign limit_hit  = (packet_count_reg >= packet_limit);

    // step logic for one item
    always_comb
    begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        length_word_next  = length_word_reg;
        time_capture_next = time_capture_reg;
        gate_nonzero_next = gate_nonzero_reg;
        first_time_next   = first_time_reg;
        last_time_next    = last_time_reg;
        have_first_next   = have_first_reg;
        packet_count_next = packet_count_reg;
        walk_stopped_next = walk_stopped_reg;
        emit_req          = 1'b0;
        done_req          = 1'b0;
        clear_req         = 1'b0;
        cause             = CAUSE_END_MARK;

        if (step)
        begin
            if (item.stream_end)
            begin
                clear_req = 1'b1;
                if (!walk_stopped_reg)
                begin
                    emit_req = 1'b1;
                    cause    = (phase_reg == PH_TYPE && limit_hit) ? CAUSE_LIMIT
                                                                   : CAUSE_INPUT_END;
                end
            end
            else if (!walk_stopped_reg)
            begin
                unique case (phase_reg)
                    PH_TYPE:
                    begin
                        if (limit_hit)
                        begin
                            emit_req = 1'b1;
                            cause    = CAUSE_LIMIT;
                        end
                        else if (item.stream_byte == TYPE_END)
                        begin
                            emit_req = 1'b1;
                            cause    = CAUSE_END_MARK;
                        end
                        else if (item.stream_byte == TYPE_ARCHIVE)
                        begin
                            phase_next        = PH_ARCHIVE;
                            byte_count_next   = 24'd1;
                            time_capture_next = '0;
                            gate_nonzero_next = 1'b0;
                        end
                        else if (item.stream_byte == TYPE_SHORT
                                 || item.stream_byte == TYPE_LONG)
                        begin
                            phase_next       = PH_PREFIX;
                            byte_count_next  = (item.stream_byte == TYPE_LONG) ? PREFIX_LONG
                                                                             : PREFIX_SHORT;
                            length_word_next = '0;
                        end
                        else
                        begin
                            emit_req = 1'b1;
                            cause    = CAUSE_BAD_TYPE;
                        end
                    end
                    PH_ARCHIVE:
                    begin
                        // little-endian time capture
                        if (byte_count_reg >= ARCHIVE_STAMP_POS
                            && byte_count_reg < ARCHIVE_TIME_END)
                        begin
                            time_capture_next = time_capture_reg
                                | (byte_wide << {time_lane, 3'b000});
                        end
                        if (byte_count_reg >= ARCHIVE_FLAG_POS
                            && byte_count_reg < ARCHIVE_GATE_END
                            && item.stream_byte != '0)
                        begin
                            gate_nonzero_next = 1'b1;
                        end
                        if (byte_count_reg >= ARCHIVE_LAST)
                        begin
                            if (!have_first_reg)
                            begin
                                first_time_next = time_capture_reg;
                            end
                            have_first_next = 1'b1;
                            last_time_next  = time_capture_reg;
                            if (gate_nonzero_reg)
                            begin
                                phase_next      = PH_GATE;
                                byte_count_next = GATE_EXTRA;
                            end
                            else
                            begin
                                done_req = 1'b1;
                            end
                        end
                        else
                        begin
                            byte_count_next = byte_count_reg + 24'd1;
                        end
                    end
                    PH_GATE, PH_PAYLOAD:
                    begin
                        byte_count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            done_req = 1'b1;
                        end
                    end
                    PH_PREFIX:
                    begin
                        byte_count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            phase_next       = PH_LEN;
                            length_word_next = '0;
                        end
                    end
                    PH_LEN:
                    begin
                        length_word_next = len_merged;
                        if (byte_count_reg[1:0] == 2'd3)
                        begin
                            if (len_merged > {8'd0, max_payload})
                            begin
                                emit_req = 1'b1;
                                cause    = CAUSE_TOO_LONG;
                            end
                            else if (len_merged == '0)
                            begin
                                done_req = 1'b1;
                            end
                            else
                            begin
                                phase_next      = PH_PAYLOAD;
                                byte_count_next = len_merged[COUNT_W-1:0];
                            end
                        end
                        else
                        begin
                            byte_count_next = byte_count_reg + 24'd1;
                        end
                    end
                    default:
                    begin
                        phase_next      = PH_TYPE;
                        byte_count_next = '0;
                    end
                endcase
            end
        end

        // packet complete: count it and check the limit
        if (done_req)
        begin
            packet_count_next = count_inc;
            phase_next        = PH_TYPE;
            byte_count_next   = '0;
            if (count_inc >= packet_limit)
            begin
                emit_req = 1'b1;
                cause    = CAUSE_LIMIT;
            end
        end

        if (emit_req)
        begin
            walk_stopped_next = 1'b1;
        end

        // duration from the times as they stand after this item
        diff    = {last_time_next[WORD_W-1], last_time_next}
                - {first_time_next[WORD_W-1], first_time_next};
        diff_ok = have_first_next && !diff[WORD_W] && (diff != '0) && (diff < DAY_MS);

        // end of input clears the walk
        if (clear_req)
        begin
            phase_next        = PH_TYPE;
            byte_count_next   = '0;
            length_word_next  = '0;
            time_capture_next = '0;
            gate_nonzero_next = 1'b0;
            first_time_next   = '0;
            last_time_next    = '0;
            have_first_next   = 1'b0;
            packet_count_next = '0;
            walk_stopped_next = 1'b0;
        end

        result.valid    = emit_req;
        result.duration = diff_ok ? diff[DUR_W-1:0] : '1;
        result.cause    = cause;
    end

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TYPE;
            byte_count_reg   <= '0;
            length_word_reg  <= '0;
            time_capture_reg <= '0;
            gate_nonzero_reg <= 1'b0;
            first_time_reg   <= '0;
            last_time_reg    <= '0;
            have_first_reg   <= 1'b0;
            packet_count_reg <= '0;
            walk_stopped_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            length_word_reg  <= length_word_next;
            time_capture_reg <= time_capture_next;
            gate_nonzero_reg <= gate_nonzero_next;
            first_time_reg   <= first_time_next;
            last_time_reg    <= last_time_next;
            have_first_reg   <= have_first_next;
            packet_count_reg <= packet_count_next;
            walk_stopped_reg <= walk_stopped_next;
        end
    end

endmodule

`default_nettype wire

>>> design/dpsw_out_stage.sv
`default_nettype none

module dpsw_out_stage
    import dpsw_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t result,
    input  wire logic    result_ready,
    output logic         result_valid,
    output logic         space,
    output logic [DUR_W-1:0] duration,
    output cause_t       cause
);

    logic             valid_reg;
    logic             valid_next;
    logic [DUR_W-1:0] duration_reg;
    cause_t           cause_reg;

    // free when empty or being drained this cycle
    assign space      = !valid_reg || result_ready;
    assign valid_next = (load && result.valid) || (valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load && result.valid)
        begin
            duration_reg <= result.duration;
            cause_reg    <= result.cause;
        end
    end

    assign result_valid = valid_reg;
    assign duration     = duration_reg;
    assign cause        = cause_reg;

endmodule

`default_nettype wire
